// File: rtl/ddo_pkg.sv
// shared types, constants and tables for the differential drive odometry core
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int CORDIC_ITERS_DEF = 24;

    localparam int ACC_W  = 104;
    localparam int MQ_W   = 40;
    localparam int TRIG_W = 36;
    localparam int CNT_W  = 6;

    localparam int MUL1_LEN = 32;
    localparam int VMUL_LEN = 39;
    localparam int POS_LEN  = 36;
    localparam int DIV_LEN  = 31;

    localparam logic [1:0] REG_DIST_PER_TICK  = 2'd0;
    localparam logic [1:0] REG_ANGLE_PER_DIFF = 2'd1;
    localparam logic [1:0] REG_VEL_TIMEOUT    = 2'd2;

    localparam logic [31:0] DIST_PER_TICK_RST  = 32'd1545371;
    localparam logic [31:0] ANGLE_PER_DIFF_RST = 32'd1508920;
    localparam logic [30:0] VEL_TIMEOUT_RST    = 31'd200000;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic [MQ_W-1:0] MICRO_K  = 40'd1000000;
    localparam logic [MQ_W-1:0] TWO_PI_K = 40'd411774832291;

    localparam logic [31:0] VEL_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_NEG_SAT = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_ANGLE,
        ST_VMUL,
        ST_DSET,
        ST_POS,
        ST_FIN
    } ddo_state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            5'd31: r = 32'h00000000;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ddo_in_if.sv
// request channel carrying encoder samples and publish requests
`timescale 1ns / 1ps

interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        timestamp_us;

    modport source (output valid, req_type, left_count, right_count, timestamp_us,
                    input ready);
    modport sink (input valid, req_type, left_count, right_count, timestamp_us,
                  output ready);
endinterface

// File: rtl/ddo_out_if.sv
// result channel carrying pose and velocities
`timescale 1ns / 1ps

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;

    modport source (output valid, pos_x, pos_y, heading, linear_velocity,
                    angular_velocity, input ready);
    modport sink (input valid, pos_x, pos_y, heading, linear_velocity,
                  angular_velocity, output ready);
endinterface

// File: rtl/ddo_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface ddo_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/differential_drive_odometry_core.sv
// differential drive wheel odometry core with serial multiply, cordic and divide
// a publish request's result is registered and appears in the cycle after acceptance
// a fresh sample occupies the core through prep, mul1, angle, vmul, dset, pos and fin,
// paced by the bit-serial multipliers, with cordic and divide running alongside
// other samples are handled in idle; requests are taken while a result waits unless it blocks
// reset: asynchronous, clears pose, velocities, history and loads default registers
`timescale 1ns / 1ps

module differential_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ddo_in_if.sink    sample,
    ddo_out_if.source result,
    ddo_cfg_if.sink   cfg
);

    ddo_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;

    logic [31:0] dist_per_tick_reg, angle_per_diff_reg;
    logic [30:0] vel_timeout_reg;

    logic        init_reg;
    logic [31:0] last_left_reg, last_right_reg, last_sample_reg, last_fresh_reg;
    logic [63:0] x_acc_reg, y_acc_reg;
    logic [31:0] heading_reg, lin_vel_reg, ang_vel_reg;

    logic        out_valid_reg;
    logic [63:0] out_x_reg, out_y_reg;
    logic [31:0] out_head_reg, out_lin_reg, out_ang_reg;

    logic [31:0] dl_reg, dr_reg, dt_reg;
    logic        sneg_reg, dneg_reg, fold_reg, cneg_reg, tsneg_reg;
    logic [63:0] travel_reg;

    logic [ACC_W-1:0] acc0_reg, acc1_reg, mc0_reg, mc1_reg;
    logic [MQ_W-1:0]  mq0_reg, mq1_reg;

    logic signed [TRIG_W-1:0] cx_reg, cy_reg;
    logic [31:0]              cz_reg;

    logic [31:0]       rem0_reg, rem1_reg;
    logic [DIV_LEN-1:0] nq0_reg, nq1_reg;
    logic              ovf0_reg, ovf1_reg;

    logic in_acc, out_free, cfg_acc, pub_acc;
    logic [31:0] dt_in, fresh_age;
    logic        timed_out;

    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid;
    assign out_free  = !out_valid_reg || result.ready;
    assign in_acc    = sample.valid && sample.ready;
    assign pub_acc   = in_acc && sample.req_type && init_reg;
    assign dt_in     = sample.timestamp_us - last_sample_reg;
    assign fresh_age = sample.timestamp_us - last_fresh_reg;
    assign timed_out = fresh_age > {1'b0, vel_timeout_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !sample.req_type && init_reg && (dt_in != 32'd0))
                    state_next = ST_PREP;
            end
            ST_PREP:  state_next = ST_MUL1;
            ST_MUL1:  if (cnt_reg == CNT_W'(MUL1_LEN - 1)) state_next = ST_ANGLE;
            ST_ANGLE: state_next = ST_VMUL;
            ST_VMUL:  if (cnt_reg == CNT_W'(VMUL_LEN - 1)) state_next = ST_DSET;
            ST_DSET:  state_next = ST_POS;
            ST_POS:   if (cnt_reg == CNT_W'(POS_LEN - 1)) state_next = ST_FIN;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        sample.ready = (state_reg == ST_IDLE) && out_free;
    end

    assign result.valid            = out_valid_reg;
    assign result.pos_x            = out_x_reg;
    assign result.pos_y            = out_y_reg;
    assign result.heading          = out_head_reg;
    assign result.linear_velocity  = out_lin_reg;
    assign result.angular_velocity = out_ang_reg;

    // datapath helpers
    logic signed [33:0] sum_s, diff_s;
    logic [32:0]        smag, dmag;
    logic [63:0]        raw_turn;
    logic [31:0]        mid_ang;
    logic signed [TRIG_W-1:0] cdx, cdy, c_fin, s_fin;
    logic [TRIG_W-1:0]  c_mag, s_mag;
    logic [32:0]        t0, t1;
    logic               q0, q1;
    logic [63:0]        r0, r1;
    logic [31:0]        q0w, q1w;

    always_comb
    begin
        sum_s  = 34'(signed'(dl_reg)) + 34'(signed'(dr_reg));
        diff_s = 34'(signed'(dr_reg)) - 34'(signed'(dl_reg));
        smag   = sum_s[33] ? 33'(-sum_s) : sum_s[32:0];
        dmag   = diff_s[33] ? 33'(-diff_s) : diff_s[32:0];
        raw_turn = dneg_reg ? (64'd0 - acc1_reg[63:0]) : acc1_reg[63:0];
        mid_ang  = heading_reg + raw_turn[32:1];
        cdx = cy_reg >>> cnt_reg[4:0];
        cdy = cx_reg >>> cnt_reg[4:0];
        c_fin = fold_reg ? -cx_reg : cx_reg;
        s_fin = fold_reg ? -cy_reg : cy_reg;
        c_mag = c_fin[TRIG_W-1] ? TRIG_W'(-c_fin) : c_fin;
        s_mag = s_fin[TRIG_W-1] ? TRIG_W'(-s_fin) : s_fin;
        t0 = {rem0_reg, nq0_reg[DIV_LEN-1]};
        t1 = {rem1_reg, nq1_reg[DIV_LEN-1]};
        q0 = t0 >= {1'b0, dt_reg};
        q1 = t1 >= {1'b0, dt_reg};
        r0 = acc0_reg[94:31];
        r1 = acc1_reg[94:31];
        q0w = {1'b0, nq0_reg};
        q1w = {1'b0, nq1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            dist_per_tick_reg  <= DIST_PER_TICK_RST;
            angle_per_diff_reg <= ANGLE_PER_DIFF_RST;
            vel_timeout_reg    <= VEL_TIMEOUT_RST;
            init_reg           <= 1'b0;
            last_left_reg      <= '0;
            last_right_reg     <= '0;
            last_sample_reg    <= '0;
            last_fresh_reg     <= '0;
            x_acc_reg          <= '0;
            y_acc_reg          <= '0;
            heading_reg        <= '0;
            lin_vel_reg        <= '0;
            ang_vel_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? '0 : cnt_reg + CNT_W'(1);

            if (cfg_acc)
            begin
                unique case (cfg.index)
                    REG_DIST_PER_TICK:  dist_per_tick_reg  <= cfg.data;
                    REG_ANGLE_PER_DIFF: angle_per_diff_reg <= cfg.data;
                    REG_VEL_TIMEOUT:    vel_timeout_reg    <= cfg.data[30:0];
                    default: ;
                endcase
            end

            if (pub_acc)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pub_acc)
                    begin
                        out_x_reg     <= x_acc_reg;
                        out_y_reg     <= y_acc_reg;
                        out_head_reg  <= heading_reg;
                        out_lin_reg   <= timed_out ? 32'd0 : lin_vel_reg;
                        out_ang_reg   <= timed_out ? 32'd0 : ang_vel_reg;
                        if (timed_out)
                        begin
                            lin_vel_reg <= '0;
                            ang_vel_reg <= '0;
                        end
                    end
                    else if (in_acc && !sample.req_type)
                    begin
                        if (!init_reg)
                        begin
                            init_reg        <= 1'b1;
                            last_left_reg   <= sample.left_count;
                            last_right_reg  <= sample.right_count;
                            last_sample_reg <= sample.timestamp_us;
                            last_fresh_reg  <= sample.timestamp_us;
                        end
                        else if (dt_in == 32'd0)
                        begin
                            last_sample_reg <= sample.timestamp_us;
                        end
                        else
                        begin
                            dl_reg          <= sample.left_count - last_left_reg;
                            dr_reg          <= sample.right_count - last_right_reg;
                            dt_reg          <= dt_in;
                            last_left_reg   <= sample.left_count;
                            last_right_reg  <= sample.right_count;
                            last_sample_reg <= sample.timestamp_us;
                            last_fresh_reg  <= sample.timestamp_us;
                        end
                    end
                end
                ST_PREP:
                begin
                    sneg_reg <= sum_s[33];
                    dneg_reg <= diff_s[33];
                    mc0_reg  <= ACC_W'(smag);
                    mc1_reg  <= ACC_W'(dmag);
                    mq0_reg  <= MQ_W'(dist_per_tick_reg);
                    mq1_reg  <= MQ_W'(angle_per_diff_reg);
                    acc0_reg <= '0;
                    acc1_reg <= '0;
                end
                ST_MUL1, ST_VMUL, ST_POS:
                begin
                    if (mq0_reg[0]) acc0_reg <= acc0_reg + mc0_reg;
                    if (mq1_reg[0]) acc1_reg <= acc1_reg + mc1_reg;
                    mc0_reg <= mc0_reg << 1;
                    mc1_reg <= mc1_reg << 1;
                    mq0_reg <= mq0_reg >> 1;
                    mq1_reg <= mq1_reg >> 1;
                    if ((state_reg == ST_VMUL) && (cnt_reg < CNT_W'(CORDIC_ITERS)))
                    begin
                        if (cz_reg[31])
                        begin
                            cx_reg <= cx_reg + cdx;
                            cy_reg <= cy_reg - cdy;
                            cz_reg <= cz_reg + atan_turn(cnt_reg[4:0]);
                        end
                        else
                        begin
                            cx_reg <= cx_reg - cdx;
                            cy_reg <= cy_reg + cdy;
                            cz_reg <= cz_reg - atan_turn(cnt_reg[4:0]);
                        end
                    end
                    if ((state_reg == ST_POS) && (cnt_reg < CNT_W'(DIV_LEN)))
                    begin
                        rem0_reg <= q0 ? 32'(t0 - {1'b0, dt_reg}) : t0[31:0];
                        rem1_reg <= q1 ? 32'(t1 - {1'b0, dt_reg}) : t1[31:0];
                        nq0_reg  <= {nq0_reg[DIV_LEN-2:0], q0};
                        nq1_reg  <= {nq1_reg[DIV_LEN-2:0], q1};
                    end
                end
                ST_ANGLE:
                begin
                    travel_reg  <= acc0_reg[63:0];
                    heading_reg <= heading_reg + raw_turn[31:0];
                    fold_reg    <= mid_ang[31] ^ mid_ang[30];
                    cz_reg      <= {mid_ang[31] ^ (mid_ang[31] ^ mid_ang[30]), mid_ang[30:0]};
                    cx_reg      <= CORDIC_GAIN;
                    cy_reg      <= '0;
                    mc0_reg     <= ACC_W'(acc0_reg[63:0]);
                    mc1_reg     <= ACC_W'(acc1_reg[63:0]);
                    mq0_reg     <= MICRO_K;
                    mq1_reg     <= TWO_PI_K;
                    acc0_reg    <= '0;
                    acc1_reg    <= '0;
                end
                ST_DSET:
                begin
                    cneg_reg  <= c_fin[TRIG_W-1];
                    tsneg_reg <= s_fin[TRIG_W-1];
                    mc0_reg   <= ACC_W'(travel_reg);
                    mc1_reg   <= ACC_W'(travel_reg);
                    mq0_reg   <= MQ_W'(c_mag);
                    mq1_reg   <= MQ_W'(s_mag);
                    ovf0_reg  <= acc0_reg[103:48] >= 56'(dt_reg);
                    ovf1_reg  <= acc1_reg[103:63] >= 41'(dt_reg);
                    rem0_reg  <= acc0_reg[79:48];
                    rem1_reg  <= acc1_reg[94:63];
                    nq0_reg   <= acc0_reg[47:17];
                    nq1_reg   <= acc1_reg[62:32];
                    acc0_reg  <= '0;
                    acc1_reg  <= '0;
                end
                ST_FIN:
                begin
                    x_acc_reg <= x_acc_reg + ((sneg_reg ^ cneg_reg) ? (64'd0 - r0) : r0);
                    y_acc_reg <= y_acc_reg + ((sneg_reg ^ tsneg_reg) ? (64'd0 - r1) : r1);
                    if (ovf0_reg)
                        lin_vel_reg <= sneg_reg ? VEL_NEG_SAT : VEL_POS_SAT;
                    else
                        lin_vel_reg <= sneg_reg ? (32'd0 - q0w) : q0w;
                    if (ovf1_reg)
                        ang_vel_reg <= dneg_reg ? VEL_NEG_SAT : VEL_POS_SAT;
                    else
                        ang_vel_reg <= dneg_reg ? (32'd0 - q1w) : q1w;
                end
                default: ;
            endcase
        end
    end

    // checks
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> (state_reg == ST_IDLE))
        else $error("request taken while busy");

    a_result_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_acc && sample.req_type && init_reg))
        else $error("result without publish request");

    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(init_reg))
        else $error("initialized flag dropped");

    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (state_reg == ST_IDLE))
        else $error("update did not finish");

endmodule

// File: verif/tb.sv
// self-checking testbench for the differential drive odometry core
`timescale 1ns / 1ps

module tb;
    import ddo_pkg::*;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
    } pose_t;

    localparam logic [31:0] ATAN_TBL [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    logic clk;
    logic rst_n;

    ddo_in_if  sample ();
    ddo_out_if result ();
    ddo_cfg_if cfg ();

    differential_drive_odometry_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .cfg    (cfg)
    );

    // predictor state and registers
    logic [31:0] m_dpt, m_apd;
    logic [30:0] m_tmo;
    logic        m_init;
    logic [31:0] m_last_l, m_last_r, m_last_st, m_last_ft;
    logic [63:0] m_x, m_y;
    logic [31:0] m_hd, m_lv, m_av;

    pose_t pose_q[$];
    int    fails;
    bit    quiet_in, quiet_out;
    int    hold_req;
    logic [31:0] ts_now, cnt_l, cnt_r;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic void sin_cos(input logic [31:0] ang, output logic [63:0] c,
                                    output logic [63:0] s);
        logic        fold;
        logic signed [63:0] x, y, dx, dy;
        logic [31:0] z;
        fold = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        z = fold ? ang + 32'h80000000 : ang;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z[31]) begin
                x = x + dx; y = y - dy; z = z + ATAN_TBL[i];
            end else begin
                x = x - dx; y = y + dy; z = z - ATAN_TBL[i];
            end
        end
        c = fold ? -x : x;
        s = fold ? -y : y;
    endfunction

    function automatic logic [63:0] pos_delta(input logic [63:0] mag, input logic neg,
                                              input logic [63:0] trig);
        logic        tneg;
        logic [63:0] tm, r;
        logic [127:0] p;
        tneg = trig[63];
        tm = tneg ? -trig : trig;
        p = {64'd0, mag} * {64'd0, tm};
        r = p[94:31];
        return (neg != tneg) ? -r : r;
    endfunction

    function automatic logic [31:0] sat_rate(input logic [63:0] mag, input logic neg,
                                             input logic [39:0] k, input logic [31:0] dt,
                                             input int sh);
        logic [127:0] q;
        logic         big;
        q = ({64'd0, mag} * {88'd0, k}) / {96'd0, dt};
        q = q >> sh;
        big = q >= 128'h80000000;
        if (neg)
            return big ? VEL_NEG_SAT : -q[31:0];
        return big ? VEL_POS_SAT : q[31:0];
    endfunction

    task automatic predict_odometry(input logic rt, input logic [31:0] l, input logic [31:0] r,
                                    input logic [31:0] ts);
        logic [31:0] dt;
        logic signed [63:0] dl, dr, sum, diff;
        logic [63:0] smag, dmag, travel, turn, raw, c, s;
        pose_t p;
        if (rt == 1'b0) begin
            if (!m_init) begin
                m_last_l = l; m_last_r = r; m_last_st = ts; m_last_ft = ts;
                m_init = 1'b1;
                return;
            end
            dt = ts - m_last_st;
            m_last_st = ts;
            if (dt == 0)
                return;
            dl = 64'(signed'(l - m_last_l));
            dr = 64'(signed'(r - m_last_r));
            m_last_l = l; m_last_r = r; m_last_ft = ts;
            sum = dl + dr;
            diff = dr - dl;
            smag = sum[63] ? -sum : sum;
            dmag = diff[63] ? -diff : diff;
            travel = smag * {32'd0, m_dpt};
            turn = dmag * {32'd0, m_apd};
            raw = diff[63] ? -turn : turn;
            sin_cos(m_hd + raw[32:1], c, s);
            m_hd = m_hd + raw[31:0];
            m_x = m_x + pos_delta(travel, sum[63], c);
            m_y = m_y + pos_delta(travel, sum[63], s);
            m_lv = sat_rate(travel, sum[63], MICRO_K, dt, 17);
            m_av = sat_rate(turn, diff[63], TWO_PI_K, dt, 32);
            return;
        end
        if (!m_init)
            return;
        if ((ts - m_last_ft) > {1'b0, m_tmo}) begin
            m_lv = 0;
            m_av = 0;
        end
        p.pos_x = m_x; p.pos_y = m_y; p.heading = m_hd;
        p.lin_vel = m_lv; p.ang_vel = m_av;
        pose_q.push_back(p);
    endtask

    task automatic send_request(input logic rt, input logic [31:0] l, input logic [31:0] r,
                                input logic [31:0] ts);
        if (!quiet_in && $urandom_range(99) < 34) begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.req_type <= rt;
        sample.left_count <= l;
        sample.right_count <= r;
        sample.timestamp_us <= ts;
        @(posedge clk);
        while (!sample.ready) @(posedge clk);
        predict_odometry(rt, l, r, ts);
    endtask

    task automatic send_publish();
        send_request(1'b1, $urandom, $urandom, ts_now + $urandom_range(0, 400));
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_DIST_PER_TICK:  m_dpt = val;
            REG_ANGLE_PER_DIFF: m_apd = val;
            REG_VEL_TIMEOUT:    m_tmo = val[30:0];
            default: ;
        endcase
    endtask

    task automatic random_sample();
        int k;
        k = $urandom_range(99);
        if (k < 4) ts_now = ts_now;
        else if (k < 8) ts_now = ts_now + $urandom;
        else if (k < 12) ts_now = ts_now + {1'b0, m_tmo} + $urandom_range(1, 1000);
        else ts_now = ts_now + $urandom_range(1, 5000);
        k = $urandom_range(99);
        if (k < 5) begin
            cnt_l = $urandom;
            cnt_r = $urandom;
        end else begin
            cnt_l = cnt_l + 32'($urandom_range(0, 4000)) - 32'd2000;
            cnt_r = cnt_r + 32'($urandom_range(0, 4000)) - 32'd2000;
        end
        send_request(1'b0, cnt_l, cnt_r, ts_now);
    endtask

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 55)
                random_sample();
            else
                send_publish();
        end
    endtask

    task automatic test_directed();
        send_request(1'b1, 0, 0, 0);
        ts_now = 32'hFFFF_FF00;
        cnt_l = 32'h7FFF_FFFF; cnt_r = 32'h8000_0000;
        send_request(1'b0, cnt_l, cnt_r, ts_now);
        send_publish();
        send_request(1'b0, 32'h1234, 32'h5678, ts_now);
        send_publish();
        ts_now = ts_now + 32'h200;
        cnt_l = 32'h8000_0000; cnt_r = 32'h7FFF_FFFF;
        send_request(1'b0, cnt_l, cnt_r, ts_now);
        send_publish();
        ts_now = ts_now + 1;
        cnt_l = cnt_l - 100; cnt_r = cnt_r + 100;
        send_request(1'b0, cnt_l, cnt_r, ts_now);
        send_publish();
        ts_now = ts_now + 32'hFFFF_FFFF;
        send_request(1'b0, cnt_l + 5, cnt_r + 5, ts_now);
        cnt_l = cnt_l + 5; cnt_r = cnt_r + 5;
        send_request(1'b1, 32'hFFFF_FFFF, 32'h0, ts_now + 200000);
        send_request(1'b1, 32'h0, 32'hFFFF_FFFF, ts_now + 200001);
        send_request(1'b1, 0, 0, ts_now + 10);
        drain();
    endtask

    task automatic test_config_sweep();
        logic [31:0] dpt_v[4] = '{32'd1, 32'hFFFF_FFFF, 32'd1545371, 32'h0000_0000};
        logic [31:0] apd_v[4] = '{32'hFFFF_FFFF, 32'd1, 32'h0000_0000, 32'd1508920};
        logic [31:0] tmo_v[4] = '{32'd0, 32'h7FFF_FFFF, 32'd3000, 32'd200000};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_DIST_PER_TICK, dpt_v[ph]);
            write_reg(REG_ANGLE_PER_DIFF, apd_v[ph]);
            write_reg(REG_VEL_TIMEOUT, tmo_v[ph]);
            random_items(60);
            drain();
        end
        write_reg(REG_DIST_PER_TICK, $urandom);
        write_reg(REG_ANGLE_PER_DIFF, $urandom);
        write_reg(REG_VEL_TIMEOUT, 32'($urandom % 32'd400000));
    endtask

    task automatic test_backpressure();
        hold_req = 3000;
        for (int i = 0; i < 40; i++)
            send_publish();
        drain();
    endtask

    task automatic test_random();
        random_items(300);
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        random_items(150);
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        random_items(300);
        drain();
    endtask

    // result side ready, with random stalls and a long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        result.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                result.ready <= 1'b0;
            end else begin
                result.ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 34);
            end
        end
    end

    // compare each result with the oldest expected pose
    initial begin
        pose_t e;
        forever begin
            @(posedge clk);
            if (rst_n && result.valid && result.ready) begin
                if (pose_q.size() == 0) begin
                    $error("result with no request waiting");
                    fails++;
                end else begin
                    e = pose_q.pop_front();
                    if (result.pos_x !== e.pos_x) begin
                        $error("pos_x exp %h got %h", e.pos_x, result.pos_x); fails++;
                    end
                    if (result.pos_y !== e.pos_y) begin
                        $error("pos_y exp %h got %h", e.pos_y, result.pos_y); fails++;
                    end
                    if (result.heading !== e.heading) begin
                        $error("heading exp %h got %h", e.heading, result.heading); fails++;
                    end
                    if (result.linear_velocity !== e.lin_vel) begin
                        $error("linear_velocity exp %h got %h", e.lin_vel,
                               result.linear_velocity);
                        fails++;
                    end
                    if (result.angular_velocity !== e.ang_vel) begin
                        $error("angular_velocity exp %h got %h", e.ang_vel,
                               result.angular_velocity);
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        fails = 0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        hold_req = 0;
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.req_type = 1'b0;
        sample.left_count = 0;
        sample.right_count = 0;
        sample.timestamp_us = 0;
        cfg.valid = 1'b0;
        cfg.index = REG_DIST_PER_TICK;
        cfg.data = 0;
        m_dpt = DIST_PER_TICK_RST;
        m_apd = ANGLE_PER_DIFF_RST;
        m_tmo = VEL_TIMEOUT_RST;
        m_init = 1'b0;
        m_last_l = 0; m_last_r = 0; m_last_st = 0; m_last_ft = 0;
        m_x = 0; m_y = 0; m_hd = 0; m_lv = 0; m_av = 0;
        ts_now = 0; cnt_l = 0; cnt_r = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        if (pose_q.size() != 0) begin
            $error("%0d expected results never arrived", pose_q.size());
            fails++;
        end
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
